### src/lfsq_pkg.sv
`timescale 1ns / 1ps

package lfsq_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 4096;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int SIZE_W = $clog2(MAX_COLS + 1);

    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [COL_W-1:0]  col_t;

    localparam row_t  ROW_LAST   = row_t'(MAX_ROWS - 1);
    localparam size_t COLS_RESET = size_t'(MAX_COLS);

    // one queued result
    typedef struct packed {
        size_t size;
        row_t  row;
        col_t  col;
    } result_t;

endpackage

### src/lfsq_cell_if.sv
`timescale 1ns / 1ps

interface lfsq_cell_if;
    import lfsq_pkg::*;

    logic valid;
    logic ready;
    logic cell_blocked;
    logic last_cell;

    modport source (output valid, output cell_blocked, output last_cell, input ready);
    modport sink (input valid, input cell_blocked, input last_cell, output ready);
endinterface

### src/lfsq_result_if.sv
`timescale 1ns / 1ps

interface lfsq_result_if;
    import lfsq_pkg::*;

    logic  valid;
    logic  ready;
    size_t square_size;
    row_t  corner_row;
    col_t  corner_col;

    modport source (output valid, output square_size, output corner_row,
                    output corner_col, input ready);
    modport sink (input valid, input square_size, input corner_row,
                  input corner_col, output ready);
endinterface

### src/lfsq_cfg_if.sv
`timescale 1ns / 1ps

interface lfsq_cfg_if;
    import lfsq_pkg::*;

    logic  valid;
    logic  ready;
    size_t col_count;

    modport source (output valid, output col_count, input ready);
    modport sink (input valid, input col_count, output ready);
endinterface

### src/largest_free_square_finder_core.sv
`timescale 1ns / 1ps

// largest free square finder
// cell_in: one request per grid cell in row-major order, cell_blocked marks an
//   obstacle, last_cell marks the final cell of the grid
// cfg: one write sets col_count (cells per row); 0 acts as 1, above the line
//   store depth acts as the depth; always ready, write only while idle
// result_out: one request per grid, issued for the last cell, carrying the
//   largest square side and its bottom-right row and column
// throughput: one cell per cycle while the output queue has room; the line store
//   takes one read (at accept) and one write (in the following cycle) per cell,
//   back-to-back hits on the same column are forwarded around the memory
// a result reaches result_out after its last cell is accepted by way of the
//   memory read, then the size/best update into the output queue
// a two-entry output queue keeps cells flowing while a result waits; cell_in
//   drops ready only when two results are queued or in flight
// reset: counters, best and col_count (to the store depth) are cleared; the
//   line store itself is not cleared and needs no clearing pass, since every
//   entry is written on the first row before any later row reads it
module largest_free_square_finder_core (
    input  logic                 clk,
    input  logic                 rst_n,
    lfsq_cell_if.sink            cell_in,
    lfsq_cfg_if.sink             cfg,
    lfsq_result_if.source        result_out
);
    import lfsq_pkg::*;

    // configuration
    size_t col_count_reg;
    size_t cols_eff;

    // input-side scan position
    col_t  col_index_reg, col_index_next;
    row_t  row_index_reg, row_index_next;
    logic  in_accept;
    logic  col_wrap;

    // line store
    size_t line_mem [MAX_COLS];
    size_t rd_q;

    // compute stage
    logic  s1_valid_reg;
    logic  s1_blocked_reg;
    logic  s1_last_reg;
    logic  s1_edge_reg;
    row_t  s1_row_reg;
    col_t  s1_col_reg;
    logic  fwd_reg, fwd_next;
    size_t fwd_data_reg;

    size_t left_reg, diag_reg;
    size_t best_size_reg;
    row_t  best_row_reg;
    col_t  best_col_reg;

    size_t up_val;
    size_t min_val;
    size_t size_comb;
    logic  take_best;
    result_t res_new;

    // output queue
    result_t head_reg, skid_reg;
    logic [1:0] q_count_reg;
    logic  push, pop;

    //------------------------------------------------------------
    // configuration port
    //------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= COLS_RESET;
        end
        else if (cfg.valid)
        begin
            col_count_reg <= cfg.col_count;
        end
    end

    // clamp to 1..MAX_COLS
    always_comb
    begin
        if (col_count_reg == '0)
            cols_eff = size_t'(1);
        else if (col_count_reg > COLS_RESET)
            cols_eff = COLS_RESET;
        else
            cols_eff = col_count_reg;
    end

    //------------------------------------------------------------
    // input side: accept and scan counters
    //------------------------------------------------------------
    // queued results plus a result still in the compute stage must leave
    // room for one more
    assign cell_in.ready = ({1'b0, q_count_reg} + {2'b00, s1_valid_reg & s1_last_reg})
                           < 3'd2;
    assign in_accept = cell_in.valid && cell_in.ready;

    assign col_wrap = ({1'b0, col_index_reg} + size_t'(1)) >= cols_eff;

    always_comb
    begin
        col_index_next = col_index_reg;
        row_index_next = row_index_reg;
        if (in_accept)
        begin
            if (cell_in.last_cell)
            begin
                col_index_next = '0;
                row_index_next = '0;
            end
            else if (col_wrap)
            begin
                col_index_next = '0;
                if (row_index_reg != ROW_LAST)
                    row_index_next = row_index_reg + row_t'(1);
            end
            else
            begin
                col_index_next = col_index_reg + col_t'(1);
            end
        end
    end

    // same column written by the compute stage this cycle: bypass the memory
    assign fwd_next = in_accept && s1_valid_reg && (s1_col_reg == col_index_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_index_reg  <= '0;
            row_index_reg  <= '0;
            s1_valid_reg   <= 1'b0;
            fwd_reg        <= 1'b0;
        end
        else
        begin
            col_index_reg  <= col_index_next;
            row_index_reg  <= row_index_next;
            s1_valid_reg   <= in_accept;
            if (in_accept)
                fwd_reg <= fwd_next;
        end
    end

    // stage payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_blocked_reg <= cell_in.cell_blocked;
            s1_last_reg    <= cell_in.last_cell;
            s1_edge_reg    <= (row_index_reg == '0) || (col_index_reg == '0);
            s1_row_reg     <= row_index_reg;
            s1_col_reg     <= col_index_reg;
            fwd_data_reg   <= size_comb;
        end
    end

    //------------------------------------------------------------
    // line store: read at accept, write back from the compute stage
    //------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            line_mem[s1_col_reg] <= size_comb;
        if (in_accept)
            rd_q <= line_mem[col_index_reg];
    end

    //------------------------------------------------------------
    // compute stage: square size and running best
    //------------------------------------------------------------
    assign up_val = fwd_reg ? fwd_data_reg : rd_q;

    always_comb
    begin
        min_val = up_val;
        if (left_reg < min_val)
            min_val = left_reg;
        if (diag_reg < min_val)
            min_val = diag_reg;

        if (s1_blocked_reg)
            size_comb = '0;
        else if (s1_edge_reg)
            size_comb = size_t'(1);
        else
            size_comb = min_val + size_t'(1);
    end

    assign take_best = size_comb > best_size_reg;

    always_comb
    begin
        if (take_best)
            res_new = '{size: size_comb, row: s1_row_reg, col: s1_col_reg};
        else
            res_new = '{size: best_size_reg, row: best_row_reg, col: best_col_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            diag_reg      <= '0;
            best_size_reg <= '0;
            best_row_reg  <= '0;
            best_col_reg  <= '0;
        end
        else if (s1_valid_reg)
        begin
            if (s1_last_reg)
            begin
                // grid done: start fresh
                left_reg      <= '0;
                diag_reg      <= '0;
                best_size_reg <= '0;
                best_row_reg  <= '0;
                best_col_reg  <= '0;
            end
            else
            begin
                left_reg      <= size_comb;
                diag_reg      <= up_val;
                best_size_reg <= res_new.size;
                best_row_reg  <= res_new.row;
                best_col_reg  <= res_new.col;
            end
        end
    end

    //------------------------------------------------------------
    // two-entry output queue
    //------------------------------------------------------------
    assign push = s1_valid_reg && s1_last_reg;
    assign pop  = result_out.valid && result_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_count_reg <= '0;
        end
        else
        begin
            case ({push, pop})
                2'b10:   q_count_reg <= q_count_reg + 2'd1;
                2'b01:   q_count_reg <= q_count_reg - 2'd1;
                default: q_count_reg <= q_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (q_count_reg == 2'd2)
            begin
                head_reg <= skid_reg;
                if (push)
                    skid_reg <= res_new;
            end
            else if (push)
            begin
                head_reg <= res_new;
            end
        end
        else if (push)
        begin
            if (q_count_reg == 2'd0)
                head_reg <= res_new;
            else
                skid_reg <= res_new;
        end
    end

    assign result_out.valid       = q_count_reg != 2'd0;
    assign result_out.square_size = head_reg.size;
    assign result_out.corner_row  = head_reg.row;
    assign result_out.corner_col  = head_reg.col;

`ifndef NO_ASSERTIONS
    // the ready rule must never let a result arrive at a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_count_reg == 2'd2 && !pop))
        else $error("result pushed into full output queue");

    // a free cell always yields a nonzero size, a blocked one zero
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> ((size_comb == '0) == s1_blocked_reg))
        else $error("square size disagrees with blocked flag");

    // the last cell restarts the scan at the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && cell_in.last_cell) |=> (col_index_reg == '0 && row_index_reg == '0))
        else $error("scan position not cleared after last cell");

    // forwarding only follows a write by the compute stage to the same column
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && fwd_next) |=> (s1_col_reg == $past(s1_col_reg)))
        else $error("forward taken for a different column");
`endif

endmodule

### tb/sv/tb_largest_free_square_finder_core.sv
`timescale 1ns / 1ps

module tb_largest_free_square_finder_core;
    import lfsq_pkg::*;

    localparam int LONG_HOLD      = 300;   // result channel held off once, in cycles
    localparam int SETTLE_CYCLES  = 6;     // covers the block latency, plus margin
    localparam int WATCHDOG_LIMIT = 3000;  // cycles in a row with no transfer at all
    localparam int RANDOM_CELLS   = 750;
    localparam int PREFILL_COLS   = 64;    // line store entries written before random grids
    localparam int CFG_ALL_ONES   = (1 << SIZE_W) - 1;

    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_LIGHT_STALL,
        RX_HEAVY_STALL
    } rx_mode_t;

    // tracks the square sizes of the grid and queues the result each grid should give
    class square_scoreboard;
        size_t   cols_reg;
        size_t   line_sizes[MAX_COLS];
        bit      line_written[MAX_COLS];
        size_t   left_sz;
        size_t   diag_sz;
        row_t    row_idx;
        int      col_idx;
        size_t   best_sz;
        row_t    best_r;
        col_t    best_c;
        size_t   widest;
        result_t expected_q[$];
        int      errors;
        int      grids_checked;

        function new();
            cols_reg = COLS_RESET;
            for (int i = 0; i < MAX_COLS; i++)
            begin
                line_sizes[i]   = '0;
                line_written[i] = 1'b0;
            end
            left_sz = '0;
            diag_sz = '0;
            row_idx = '0;
            col_idx = 0;
            best_sz = '0;
            best_r  = '0;
            best_c  = '0;
            widest  = '0;
            errors  = 0;
            grids_checked = 0;
        endfunction

        function void write_cols(size_t v);
            cols_reg = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // true when a row of n columns reads only entries already written
        function bit columns_written(int n);
            for (int i = 0; i < n; i++)
                if (!line_written[i])
                    return 1'b0;
            return 1'b1;
        endfunction

        function void note_cell(bit blocked, bit last);
            int      cols;
            size_t   up;
            size_t   sz;
            result_t r;
            if (cols_reg == 0)
                cols = 1;
            else if (cols_reg > MAX_COLS)
                cols = MAX_COLS;
            else
                cols = int'(cols_reg);
            up = line_sizes[col_idx];
            if (blocked)
                sz = '0;
            else if (row_idx == 0 || col_idx == 0)
                sz = size_t'(1);
            else
            begin
                sz = up;
                if (left_sz < sz)
                    sz = left_sz;
                if (diag_sz < sz)
                    sz = diag_sz;
                sz = sz + 1'b1;
            end
            line_sizes[col_idx]   = sz;
            line_written[col_idx] = 1'b1;
            diag_sz = up;
            left_sz = sz;
            // strictly larger only, so the first maximum in scan order stays
            if (sz > best_sz)
            begin
                best_sz = sz;
                best_r  = row_idx;
                best_c  = col_t'(col_idx);
            end
            if (last)
            begin
                r.size = best_sz;
                r.row  = best_r;
                r.col  = best_c;
                expected_q.push_back(r);
                if (best_sz > widest)
                    widest = best_sz;
                best_sz = '0;
                best_r  = '0;
                best_c  = '0;
                row_idx = '0;
                col_idx = 0;
                left_sz = '0;
                diag_sz = '0;
                return;
            end
            // the last column, or any past it, ends the row; rows stop at the last index
            if (col_idx + 1 >= cols)
            begin
                col_idx = 0;
                if (row_idx != ROW_LAST)
                    row_idx = row_idx + 1'b1;
            end
            else
                col_idx = col_idx + 1;
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_result(size_t got_size, row_t got_row, col_t got_col);
            result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result size %0d row %0d col %0d",
                                          got_size, got_row, got_col));
                return;
            end
            want = expected_q.pop_front();
            grids_checked++;
            if (got_size !== want.size)
                report_mismatch($sformatf("square_size %0d, want %0d", got_size, want.size));
            if (got_row !== want.row)
                report_mismatch($sformatf("corner_row %0d, want %0d", got_row, want.row));
            if (got_col !== want.col)
                report_mismatch($sformatf("corner_col %0d, want %0d", got_col, want.col));
        endtask
    endclass

    logic clk;
    logic rst_n;

    lfsq_cell_if   cell_in ();
    lfsq_cfg_if    cfg ();
    lfsq_result_if result_out ();

    largest_free_square_finder_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_in    (cell_in),
        .cfg        (cfg),
        .result_out (result_out)
    );

    square_scoreboard sb;

    // sender pacing: bursts of random length, gaps drawn up to gap_max
    int burst_left;
    int gap_max;
    // raised once by the stimulus, cleared by the receiver after its long hold
    bit hold_req;

    int cells_sent;
    int random_cells;
    int cfg_writes;
    int stall_cycles;
    int idle_run;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one cell request, held until the block takes it; prediction runs at the accepting edge
    task automatic send_cell(input bit blocked, input bit last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                cell_in.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cell_in.valid        <= 1'b1;
        cell_in.cell_blocked <= blocked;
        cell_in.last_cell    <= last;
        @(posedge clk);
        while (!cell_in.ready)
            @(posedge clk);
        sb.note_cell(blocked, last);
        cells_sent++;
    endtask

    // stop offering cells and let every expected grid result drain out
    task automatic settle();
        cell_in.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // a mid-grid pause leaves no result behind, so give the pipeline its latency
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // column-count write, only issued while the block is idle
    task automatic write_cols(input int v);
        cfg.valid     <= 1'b1;
        cfg.col_count <= size_t'(v);
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        sb.write_cols(size_t'(v));
        cfg_writes++;
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // one random grid: rows of free or blocked cells, sometimes a short last row,
    // sometimes a column-count change in the middle
    task automatic run_grid(input int cols_cfg, input int rows, input int pct_blocked,
                            input bit retune);
        int eff;
        int total;
        int pause_at;
        int new_cols;
        eff = (cols_cfg == 0) ? 1 : ((cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg);
        write_cols(cols_cfg);
        if (eff > 16)
            total = $urandom_range(1, 48);
        else
        begin
            total = rows * eff;
            if ($urandom_range(0, 3) == 0)
                total = total - $urandom_range(0, eff - 1);
            if (total < 1)
                total = 1;
        end
        pause_at = (retune && total > 1) ? $urandom_range(1, total - 1) : -1;
        for (int n = 0; n < total; n++)
        begin
            if (n == pause_at)
            begin
                settle();
                new_cols = $urandom_range(0, 8);
                // widening mid-grid is only legal over line store entries already written
                if (sb.columns_written((new_cols == 0) ? 1 : new_cols))
                    write_cols(new_cols);
            end
            send_cell($urandom_range(0, 99) < pct_blocked, n == total - 1);
            random_cells++;
        end
        settle();
    endtask

    // result side: stalls on a pattern of its own, with one long hold on request
    initial
    begin
        rx_mode_t mode;
        int       mode_left;
        result_out.ready <= 1'b0;
        mode      = RX_STEADY;
        mode_left = 0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                result_out.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 80);
            end
            mode_left--;
            case (mode)
                RX_STEADY:      result_out.ready <= 1'b1;
                RX_COIN:        result_out.ready <= ($urandom_range(0, 1) != 0);
                RX_LIGHT_STALL: result_out.ready <= ($urandom_range(0, 4) != 0);
                default:        result_out.ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clk);
        end
    end

    // result checking, input stall count and the no-progress watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_out.valid && result_out.ready)
                sb.check_result(result_out.square_size, result_out.corner_row,
                                result_out.corner_col);
            if (cell_in.valid && !cell_in.ready)
                stall_cycles++;
            if ((cell_in.valid && cell_in.ready) || (result_out.valid && result_out.ready)
                || (cfg.valid && cfg.ready))
                idle_run = 0;
            else
            begin
                idle_run++;
                if (idle_run >= WATCHDOG_LIMIT)
                begin
                    $display("watchdog: no transfer for %0d cycles", idle_run);
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int  cols_cfg;
        int  pct;
        bit  pressure_done;
        sb = new();
        burst_left   = 0;
        gap_max      = 2;
        hold_req     = 1'b0;
        cells_sent   = 0;
        random_cells = 0;
        cfg_writes   = 0;
        stall_cycles = 0;
        idle_run     = 0;
        pressure_done = 1'b0;

        rst_n                <= 1'b0;
        cell_in.valid        <= 1'b0;
        cell_in.cell_blocked <= 1'b0;
        cell_in.last_cell    <= 1'b0;
        cfg.valid            <= 1'b0;
        cfg.col_count        <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-cell grids at the reset column count: no free cell, then one free cell
        send_cell(1'b1, 1'b1);
        send_cell(1'b0, 1'b1);
        settle();

        // part of a full-width row, free only in its final cell: corner on that column;
        // this also writes the line store entries that later grids read
        for (int i = 0; i < PREFILL_COLS; i++)
            send_cell(i != PREFILL_COLS - 1, i == PREFILL_COLS - 1);
        settle();

        // a count of zero acts as one column
        write_cols(0);
        for (int i = 0; i < 3; i++)
            send_cell(1'b0, i == 2);
        settle();

        // three columns: two equal squares in one row keep the first, then a 3x3
        write_cols(3);
        for (int i = 0; i < 6; i++)
            send_cell(1'b0, i == 5);
        for (int i = 0; i < 9; i++)
            send_cell(1'b0, i == 8);
        settle();

        // all-ones count folds to the line store width
        write_cols(CFG_ALL_ONES);
        for (int i = 0; i < 5; i++)
            send_cell(i < 2, i == 4);
        settle();

        // random grids, mostly narrow so squares grow over several rows
        while (random_cells < RANDOM_CELLS)
        begin
            if (!pressure_done && random_cells >= RANDOM_CELLS / 2)
            begin
                // back-to-back one-cell grids while the result side holds off
                pressure_done = 1'b1;
                gap_max  = 0;
                hold_req = 1'b1;
                for (int i = 0; i < 24; i++)
                begin
                    send_cell($urandom_range(0, 1) != 0, 1'b1);
                    random_cells++;
                end
                settle();
            end
            case ($urandom_range(0, 19))
                0:       cols_cfg = 0;
                1:       cols_cfg = MAX_COLS;
                2:       cols_cfg = $urandom_range(MAX_COLS + 1, CFG_ALL_ONES);
                3:       cols_cfg = $urandom_range(9, MAX_COLS - 1);
                default: cols_cfg = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 5))
                0:       pct = 0;
                1:       pct = 5;
                2:       pct = 15;
                3:       pct = 35;
                4:       pct = 70;
                default: pct = 100;
            endcase
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            run_grid(cols_cfg, $urandom_range(1, 8), pct, $urandom_range(0, 5) == 0);
        end

        settle();
        $display("covered %0d cells in %0d grids, %0d column-count writes, largest square %0d",
                 cells_sent, sb.grids_checked, cfg_writes, sb.widest);
        $display("result side held off %0d cycles once; cell input stalled %0d cycles in all",
                 LONG_HOLD, stall_cycles);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
